[hdl/mrr_pkg.sv]
`default_nettype none

package mrr_pkg;

    // Default width of the candidate and the witness.
    localparam int NUM_WIDTH_DEF = 31;

    // Small primes that pass every round without any arithmetic.
    localparam int SMALL_PRIME_LO = 2;
    localparam int SMALL_PRIME_HI = 3;

    // Round sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_FACTOR,
        S_REDUCE,
        S_POW_TEST,
        S_POW_MUL,
        S_POW_SQR,
        S_SQR_TEST,
        S_SQR,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

[hdl/miller_rabin_round.sv]
`default_nettype none

// Channel   Direction  Word contents                                     Condition
// s_axis    in         tdata: candidate, witness; tlast: last_round     tvalid && tready
// m_axis    out        tdata: probably_prime                             tvalid && tready
//
// One round runs at a time; the input is ready only while the sequencer idles.
// Each modular product uses one shared shift-and-add unit, one multiplier bit per
// cycle. A round takes up to 2*NUM_WIDTH+1 products, plus the stripping of the
// trailing zeros of n-1. A stalled output holds the sequencer only when a second
// verdict is ready. Reset is synchronous and active low and sets the pass flag.

module miller_rabin_round
    import mrr_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // Bits from the lowest up: candidate, witness, zero fill.
    input  wire logic [((2*NUM_WIDTH+7)/8)*8-1:0]   i_s_tdata,
    // Marks the last round of a run.
    input  wire logic                               i_s_tlast,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // Bits from the lowest up: probably_prime, zero fill.
    output logic [7:0]                              o_m_tdata
);

    localparam int W  = NUM_WIDTH;
    localparam int SW = $clog2(NUM_WIDTH);

    // (a + b) mod m for a, b below m.
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a,
                                             input logic [W-1:0] b,
                                             input logic [W-1:0] m);
        logic [W+1:0] sum;
        logic [W+1:0] dif;
        sum = {2'b00, a} + {2'b00, b};
        dif = sum - {2'b00, m};
        return dif[W+1] ? sum[W-1:0] : dif[W-1:0];
    endfunction

    t_state           r_state, n_state;
    logic [W-1:0]     r_n, n_n;
    logic [W-1:0]     r_nm1, n_nm1;
    logic [W-1:0]     r_e, n_e;
    logic [SW-1:0]    r_s, n_s;
    logic [W-1:0]     r_b, n_b;
    logic [W-1:0]     r_res, n_res;
    logic [W-1:0]     r_acc, n_acc;
    logic [W-1:0]     r_mx, n_mx;
    logic [W-1:0]     r_my, n_my;
    logic             r_pass, n_pass;
    logic             r_last, n_last;
    logic             r_all, n_all;
    logic             r_out_valid, n_out_valid;
    logic             r_out_bit, n_out_bit;

    logic [W-1:0]     in_cand;
    logic [W-1:0]     in_wit;
    logic             in_accept;
    logic             in_trivial;
    logic             mul_done;
    logic             verdict;
    logic             out_free;
    logic [W-1:0]     one_w;

    assign in_cand    = i_s_tdata[W-1:0];
    assign in_wit     = i_s_tdata[2*W-1:W];
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign in_trivial = (in_cand < W'(SMALL_PRIME_LO)) ||
                        (in_cand == W'(SMALL_PRIME_LO)) ||
                        (in_cand == W'(SMALL_PRIME_HI));
    assign mul_done   = (r_my == '0);
    assign verdict    = r_all && r_pass;
    assign out_free   = !r_out_valid || i_m_tready;
    assign one_w      = W'(1);

    // Ports.
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0000000, r_out_bit};

    // Next state of the round sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = in_trivial ? S_FINISH : S_FACTOR;
                end
            end
            S_FACTOR: begin
                if (r_e[0]) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (mul_done) begin
                    n_state = S_POW_TEST;
                end
            end
            S_POW_TEST: begin
                priority if (r_e == '0) begin
                    n_state = ((r_res == one_w) || (r_res == r_nm1)) ? S_FINISH : S_SQR_TEST;
                end else if (r_e[0]) begin
                    n_state = S_POW_MUL;
                end else begin
                    n_state = S_POW_SQR;
                end
            end
            S_POW_MUL: begin
                if (mul_done) begin
                    n_state = S_POW_SQR;
                end
            end
            S_POW_SQR: begin
                if (mul_done) begin
                    n_state = S_POW_TEST;
                end
            end
            S_SQR_TEST: begin
                n_state = (r_s <= SW'(1)) ? S_FINISH : S_SQR;
            end
            S_SQR: begin
                if (mul_done) begin
                    n_state = ((r_acc == r_nm1) || (r_acc == one_w)) ? S_FINISH : S_SQR_TEST;
                end
            end
            S_FINISH: begin
                if (!r_last || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        n_n         = r_n;
        n_nm1       = r_nm1;
        n_e         = r_e;
        n_s         = r_s;
        n_b         = r_b;
        n_res       = r_res;
        n_acc       = r_acc;
        n_mx        = r_mx;
        n_my        = r_my;
        n_pass      = r_pass;
        n_last      = r_last;
        n_all       = r_all;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_bit   = r_out_bit;

        // Shared multiply unit: one multiplier bit per cycle, low bit first.
        if (!mul_done) begin
            if (r_my[0]) begin
                n_acc = add_mod(r_acc, r_mx, r_n);
            end
            n_mx = add_mod(r_mx, r_mx, r_n);
            n_my = r_my >> 1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_n    = in_cand;
                    n_nm1  = in_cand - one_w;
                    n_e    = in_cand - one_w;
                    n_s    = '0;
                    n_b    = in_wit;
                    n_last = i_s_tlast;
                    n_pass = (in_cand >= W'(SMALL_PRIME_LO));
                end
            end
            S_FACTOR: begin
                // Strip trailing zeros of n-1; then reduce the witness as 1 * witness mod n.
                if (r_e[0]) begin
                    n_acc = '0;
                    n_mx  = one_w;
                    n_my  = r_b;
                end else begin
                    n_e = r_e >> 1;
                    n_s = r_s + SW'(1);
                end
            end
            S_REDUCE: begin
                if (mul_done) begin
                    n_b   = r_acc;
                    n_res = one_w;
                end
            end
            S_POW_TEST: begin
                priority if (r_e == '0) begin
                    n_pass = (r_res == one_w) || (r_res == r_nm1);
                end else if (r_e[0]) begin
                    n_acc = '0;
                    n_mx  = r_res;
                    n_my  = r_b;
                end else begin
                    n_acc = '0;
                    n_mx  = r_b;
                    n_my  = r_b;
                end
            end
            S_POW_MUL: begin
                if (mul_done) begin
                    n_res = r_acc;
                    n_acc = '0;
                    n_mx  = r_b;
                    n_my  = r_b;
                end
            end
            S_POW_SQR: begin
                if (mul_done) begin
                    n_b = r_acc;
                    n_e = r_e >> 1;
                end
            end
            S_SQR_TEST: begin
                if (r_s <= SW'(1)) begin
                    n_pass = 1'b0;
                end else begin
                    n_acc = '0;
                    n_mx  = r_res;
                    n_my  = r_res;
                end
            end
            S_SQR: begin
                if (mul_done) begin
                    n_res  = r_acc;
                    n_s    = r_s - SW'(1);
                    n_pass = (r_acc == r_nm1);
                end
            end
            S_FINISH: begin
                // Fold the round into the run; the last round emits the verdict.
                if (!r_last) begin
                    n_all = verdict;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = verdict;
                    n_all       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_all       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_all       <= n_all;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_nm1     <= n_nm1;
        r_e       <= n_e;
        r_s       <= n_s;
        r_b       <= n_b;
        r_res     <= n_res;
        r_acc     <= n_acc;
        r_mx      <= n_mx;
        r_my      <= n_my;
        r_pass    <= n_pass;
        r_last    <= n_last;
        r_out_bit <= n_out_bit;
    end

`ifndef SYNTHESIS
    // The multiply unit keeps its partial values reduced below the modulus.
    a_mul_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_POW_MUL || r_state == S_POW_SQR || r_state == S_SQR) && !mul_done)
        |-> (r_acc < r_n) && (r_mx < r_n))
        else $error("multiply unit left its residue range");

    // Factoring only runs on a nonzero n-1.
    a_factor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FACTOR) |-> (r_e != '0))
        else $error("factoring started on a zero value");

    // A verdict appears only at the end of a last round.
    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FINISH) && $past(r_last))
        else $error("verdict raised outside the end of a last round");

    // The pass flag is set again once a verdict has been issued.
    a_flag_rearmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> r_all)
        else $error("pass flag not set after a verdict");
`endif

endmodule

`default_nettype wire
